>>> hw/rtl/sha1_hash_engine_macros.svh
// assertion macros for the sha1 engine, clocked on i_clk with i_rst_n low as reset
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH
`ifndef SYNTH
`define SHA1_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sha1 engine check failed");
`define SHA1_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sha1 engine check failed");
`else
`define SHA1_ASSERT_NOW(label, ante, cons)
`define SHA1_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/sha1_pkg.sv
package sha1_pkg;

    localparam int unsigned ROUNDS    = 80;
    localparam int unsigned HASH_WORDS = 5;
    localparam int unsigned BLK_WORDS = 16;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [5:0]  LEN_SLOT  = 6'd56;

    localparam logic [31:0] HASH_INIT [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef enum logic [1:0] {
        GRP_CH,
        GRP_PAR1,
        GRP_MAJ,
        GRP_PAR2
    } t_grp;

    // message schedule controls
    typedef struct packed {
        logic        wr_byte;
        logic [5:0]  byte_pos;
        logic [7:0]  byte_val;
        logic        wr_len;
        logic [63:0] len;
        logic        shift;
        logic        clear;
    } t_sch_ctl;

    // round unit controls
    typedef struct packed {
        logic load;
        logic step;
        logic add;
        logic init;
        t_grp grp;
    } t_rnd_ctl;

    function automatic logic [31:0] rotl1(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] v);
        return {v[26:0], v[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] v);
        return {v[1:0], v[31:2]};
    endfunction

    function automatic logic [31:0] round_k(input t_grp g);
        logic [31:0] k;
        unique case (g)
            GRP_CH:   k = 32'h5A827999;
            GRP_PAR1: k = 32'h6ED9EBA1;
            GRP_MAJ:  k = 32'h8F1BBCDC;
            GRP_PAR2: k = 32'hCA62C1D6;
            default:  k = 32'h5A827999;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] round_f(input t_grp g, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (g)
            GRP_CH:   f = (b & c) | (~b & d);
            GRP_MAJ:  f = (b & c) | (b & d) | (c & d);
            GRP_PAR1,
            GRP_PAR2: f = b ^ c ^ d;
            default:  f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

>>> hw/rtl/sha1_hash_engine.sv
// SHA-1 digest engine over a byte stream. The block is ready again right after a data
// transfer (cmd 0), except for the 64th byte of a block: that one starts a compression of
// a start state, 80 rounds on a single shared round adder (one round per cycle) and a final
// hash addition, and o_in_stall stays high through all of it. A finish transfer (cmd 1)
// pads the message and runs one or two such compressions (two when 56 or more bytes sit in
// the current block), then presents the five digest words, most significant first, one per
// output transfer; input stays stalled until the fifth word is taken, after which the engine
// is reset for the next message. No new byte is taken while a block is being compressed.
`include "sha1_hash_engine_macros.svh"

module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_PAD1,
        PH_PAD2
    } t_phase;

    t_state      r_state;
    t_phase      r_phase;
    logic [6:0]  r_round;
    logic [5:0]  r_pos;
    logic [63:0] r_bits;
    logic [2:0]  r_k;

    logic               in_xfer;
    logic               out_xfer;
    sha1_pkg::t_sch_ctl sch_ctl;
    sha1_pkg::t_rnd_ctl rnd_ctl;
    sha1_pkg::t_grp     grp;
    logic [31:0]        w;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_OUT);
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign o_word_index = r_k;
    assign o_last_word  = (r_k == 3'(sha1_pkg::HASH_WORDS - 1));

    always_comb begin
        priority if (r_round < 7'd20) grp = sha1_pkg::GRP_CH;
        else if (r_round < 7'd40)    grp = sha1_pkg::GRP_PAR1;
        else if (r_round < 7'd60)    grp = sha1_pkg::GRP_MAJ;
        else                         grp = sha1_pkg::GRP_PAR2;
    end

    always_comb begin
        sch_ctl.wr_byte  = in_xfer;
        sch_ctl.byte_pos = r_pos;
        sch_ctl.byte_val = i_cmd ? sha1_pkg::PAD_BYTE : i_data_byte;
        // length goes in now when it fits, else when the first padding compression ends, for the extra block
        sch_ctl.wr_len   = (in_xfer && i_cmd && (r_pos < sha1_pkg::LEN_SLOT))
                         || ((r_state == S_ADD) && (r_phase == PH_PAD1));
        sch_ctl.len      = r_bits;
        sch_ctl.shift    = (r_state == S_ROUND);
        sch_ctl.clear    = (r_state == S_ADD);

        rnd_ctl.load = (r_state == S_START);
        rnd_ctl.step = (r_state == S_ROUND);
        rnd_ctl.add  = (r_state == S_ADD);
        rnd_ctl.init = out_xfer && o_last_word;
        rnd_ctl.grp  = grp;
    end

    sha1_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sch_ctl),
        .o_w     (w)
    );

    sha1_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (rnd_ctl),
        .i_w         (w),
        .i_sel       (r_k),
        .o_hash_word (o_digest_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_DATA;
            r_round <= '0;
            r_pos   <= '0;
            r_bits  <= '0;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_cmd) begin
                            r_phase <= (r_pos >= sha1_pkg::LEN_SLOT) ? PH_PAD1 : PH_PAD2;
                            r_state <= S_START;
                        end else begin
                            r_bits <= r_bits + 64'd8;
                            r_pos  <= r_pos + 6'd1;
                            if (r_pos == 6'd63) begin
                                r_phase <= PH_DATA;
                                r_state <= S_START;
                            end
                        end
                    end
                end
                S_START: begin
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_round <= r_round + 7'd1;
                    if (r_round == 7'(sha1_pkg::ROUNDS - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    unique case (r_phase)
                        PH_DATA: r_state <= S_IDLE;
                        PH_PAD1: begin
                            r_phase <= PH_PAD2;
                            r_state <= S_START;
                        end
                        PH_PAD2: begin
                            r_k     <= '0;
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_OUT: begin
                    if (out_xfer) begin
                        r_k <= r_k + 3'd1;
                        if (o_last_word) begin
                            r_pos   <= '0;
                            r_bits  <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SHA1_ASSERT_NEXT(a_finish_blocks_input, in_xfer && i_cmd, o_in_stall)
    `SHA1_ASSERT_NOW(a_no_input_while_emitting, o_out_valid, o_in_stall)
    `SHA1_ASSERT_NOW(a_round_in_range, r_state == S_ROUND,
                     r_round <= 7'(sha1_pkg::ROUNDS - 1))
    `SHA1_ASSERT_NEXT(a_clean_after_digest, out_xfer && o_last_word,
                      !o_out_valid && (r_pos == 6'd0) && (r_bits == 64'd0))

endmodule

>>> hw/rtl/sha1_sched.sv
module sha1_sched (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1_pkg::t_sch_ctl i_ctl,
    output logic [31:0]        o_w
);

    logic [31:0] r_w [sha1_pkg::BLK_WORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sha1_pkg::BLK_WORDS; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            // w[t+16] enters at the tail while w[t] leaves the head
            if (i_ctl.shift) begin
                for (int i = 0; i < sha1_pkg::BLK_WORDS - 1; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[sha1_pkg::BLK_WORDS - 1] <=
                    sha1_pkg::rotl1(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]);
            end
            if (i_ctl.clear) begin
                for (int i = 0; i < sha1_pkg::BLK_WORDS - 2; i++) begin
                    r_w[i] <= '0;
                end
            end
            // the length takes the last two words, otherwise they clear with the rest
            if (i_ctl.wr_len) begin
                r_w[14] <= i_ctl.len[63:32];
                r_w[15] <= i_ctl.len[31:0];
            end else if (i_ctl.clear) begin
                r_w[14] <= '0;
                r_w[15] <= '0;
            end
            // big-endian byte lane, buffer is zero there so a plain write suffices
            if (i_ctl.wr_byte) begin
                r_w[i_ctl.byte_pos[5:2]][{~i_ctl.byte_pos[1:0], 3'b000} +: 8] <= i_ctl.byte_val;
            end
        end
    end

    assign o_w = r_w[0];

endmodule

>>> hw/rtl/sha1_round.sv
module sha1_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1_pkg::t_rnd_ctl i_ctl,
    input  logic [31:0]        i_w,
    input  logic [2:0]         i_sel,
    output logic [31:0]        o_hash_word
);

    logic [31:0] r_h [sha1_pkg::HASH_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a;

    assign n_a = sha1_pkg::rotl5(r_a) + sha1_pkg::round_f(i_ctl.grp, r_b, r_c, r_d)
               + r_e + i_w + sha1_pkg::round_k(i_ctl.grp);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_ctl.step) begin
            r_a <= n_a;
            r_b <= r_a;
            r_c <= sha1_pkg::rotl30(r_b);
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < sha1_pkg::HASH_WORDS; i++) begin
                r_h[i] <= sha1_pkg::HASH_INIT[i];
            end
        end else if (i_ctl.add) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

    always_comb begin
        unique case (i_sel)
            3'd0:    o_hash_word = r_h[0];
            3'd1:    o_hash_word = r_h[1];
            3'd2:    o_hash_word = r_h[2];
            3'd3:    o_hash_word = r_h[3];
            3'd4:    o_hash_word = r_h[4];
            default: o_hash_word = r_h[0];
        endcase
    end

endmodule
